/* hw/rtl/smvm_pkg.sv */
// ----------------------------------------------------------------------------
// smvm_pkg
// Shared types and constants of the coordinate-list sparse matrix-vector
// multiplier: sizes, command and status codes, memory request structs.
// ----------------------------------------------------------------------------
`default_nettype none

package smvm_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLS);

    localparam int IDX_W    = 10;   // row_index / col_index field width
    localparam int CFG_W    = 11;   // rows_in_use / cols_in_use width
    localparam int VAL_W    = 32;   // Q1.30 operand width
    localparam int ACC_W    = 48;   // Q17.30 accumulator width
    localparam int FRAC_W   = 30;
    localparam int PROD_W   = 2 * VAL_W - FRAC_W;  // product after the shift
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IN_DW    = 56;   // row, col, value packed, byte aligned

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_X = 2'd0,
        CMD_MAC    = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              we;
        logic [COL_AW-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [COL_AW-1:0] raddr;
    } t_xram_req;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [ACC_W-1:0]  wdata;
        logic              re;
        logic [ROW_AW-1:0] raddr;
    } t_accram_req;

endpackage

`default_nettype wire

/* hw/rtl/smvm_xram.sv */
// ----------------------------------------------------------------------------
// smvm_xram
// Storage for the x vector: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smvm_xram (
    input  wire logic                       i_clk,
    input  wire smvm_pkg::t_xram_req        i_req,
    output logic [smvm_pkg::VAL_W-1:0]      o_rdata
);
    import smvm_pkg::*;

    logic [VAL_W-1:0] r_mem [MAX_COLS];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/smvm_accram.sv */
// ----------------------------------------------------------------------------
// smvm_accram
// Row accumulator storage with a zeroing sweep after reset, one entry per
// cycle. o_ready stays low until the sweep has finished.
// ----------------------------------------------------------------------------
`default_nettype none

module smvm_accram (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire smvm_pkg::t_accram_req      i_req,
    output logic [smvm_pkg::ACC_W-1:0]      o_rdata,
    output logic                            o_ready
);
    import smvm_pkg::*;

    logic [ACC_W-1:0] r_mem [MAX_ROWS];
    logic [ACC_W-1:0] r_rdata;
    logic [ROW_AW:0]  r_clr_cnt;
    logic             w_clearing;

    assign w_clearing = (r_clr_cnt != (ROW_AW+1)'(MAX_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (w_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_mem[r_clr_cnt[ROW_AW-1:0]] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !w_clearing;

endmodule

`default_nettype wire

/* hw/rtl/sparse_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// y = A*x with A streamed as coordinate-list nonzeros, Q1.30 operands,
// 48-bit saturating row accumulators held in on-chip memory.
// ----------------------------------------------------------------------------
// Path: from input transaction to output tvalid an item passes the memory
//   read at the accept edge, the registered multiply, and add/saturate/
//   write-back into the output register, which waits for a free output.
// Ordering: the read-modify-write of one accumulator entry is completed
//   before the next item is taken.
// Reset: synchronous, active low; afterwards the accumulator memory is zeroed,
//   and no input is accepted until that is done (config is).
`default_nettype none

module sparse_matrix_vector_multiply (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic [smvm_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: row_index [9:0], col_index [19:10], value [51:20], zero pad
    input  wire logic [smvm_pkg::IN_DW-1:0]     i_s_axis_tdata,
    // tuser: cmd [1:0]
    input  wire logic [smvm_pkg::CMD_W-1:0]     i_s_axis_tuser,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: result_value [47:0]
    output logic [smvm_pkg::ACC_W-1:0]          o_m_axis_tdata,
    // tuser: status [1:0]
    output logic [smvm_pkg::STAT_W-1:0]         o_m_axis_tuser
);
    import smvm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ADD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_rows_in_use, r_cols_in_use;
    logic [CFG_W-1:0] w_row_limit, w_col_limit;

    // item registers
    t_cmd                     r_cmd;
    logic [IDX_W-1:0]         r_row, r_col;
    logic signed [VAL_W-1:0]  r_value;
    logic                     r_row_ok, r_col_ok;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // output register
    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_data;
    t_status                  r_out_stat;

    logic                     w_s_accept, w_fire, w_acc_ready;
    logic [IDX_W-1:0]         w_in_row, w_in_col;
    t_cmd                     w_in_cmd;
    logic signed [VAL_W-1:0]  w_x_rdata;
    logic [ACC_W-1:0]         w_acc_rdata;
    logic signed [2*VAL_W-1:0] w_prod_full;
    logic signed [ACC_W:0]    w_sum;
    logic                     w_ovf;
    logic [ACC_W-1:0]         w_sat_sum;
    t_xram_req                w_xreq;
    t_accram_req              w_areq;
    logic [ACC_W-1:0]         w_res;
    t_status                  w_stat;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_RESET;
            r_cols_in_use <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROWS: r_rows_in_use <= i_cfg_data;
                REG_COLS: r_cols_in_use <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign w_row_limit = (r_rows_in_use < CFG_W'(MAX_ROWS)) ? r_rows_in_use
                                                             : CFG_W'(MAX_ROWS);
    assign w_col_limit = (r_cols_in_use < CFG_W'(MAX_COLS)) ? r_cols_in_use
                                                             : CFG_W'(MAX_COLS);

    // ---------------- input side ----------------
    assign w_in_row = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_col = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_in_cmd = t_cmd'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE) && w_acc_ready;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fire          = (r_state == S_ADD) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_cmd    <= w_in_cmd;
            r_row    <= w_in_row;
            r_col    <= w_in_col;
            r_value  <= i_s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
            r_row_ok <= {1'b0, w_in_row} < w_row_limit;
            r_col_ok <= {1'b0, w_in_col} < w_col_limit;
        end
    end

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_s_accept) n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    // floor shift of the full product keeps 34 significant bits
    assign w_prod_full = r_value * w_x_rdata;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(w_prod_full >>> FRAC_W);
            r_acc  <= w_acc_rdata;
        end
    end

    assign w_sum     = {r_acc[ACC_W-1], r_acc}
                     + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_ovf     = w_sum[ACC_W] != w_sum[ACC_W-1];
    assign w_sat_sum = w_ovf ? {w_sum[ACC_W], {(ACC_W-1){!w_sum[ACC_W]}}}
                             : w_sum[ACC_W-1:0];

    always_comb begin
        w_res        = '0;
        w_stat       = ST_OK;
        w_xreq.we    = 1'b0;
        w_xreq.waddr = r_col[COL_AW-1:0];
        w_xreq.wdata = r_value;
        w_xreq.re    = w_s_accept;
        w_xreq.raddr = w_in_col[COL_AW-1:0];
        w_areq.we    = 1'b0;
        w_areq.waddr = r_row[ROW_AW-1:0];
        w_areq.wdata = '0;
        w_areq.re    = w_s_accept;
        w_areq.raddr = w_in_row[ROW_AW-1:0];
        case (r_cmd)
            CMD_LOAD_X: begin
                if (r_col_ok) w_xreq.we = w_fire;
                else          w_stat    = ST_RANGE;
            end
            CMD_MAC: begin
                if (r_row_ok && r_col_ok) begin
                    w_areq.we    = w_fire;
                    w_areq.wdata = w_sat_sum;
                    if (w_ovf) w_stat = ST_SAT;
                end else begin
                    w_stat = ST_RANGE;
                end
            end
            CMD_READ: begin
                if (r_row_ok) begin
                    w_areq.we = w_fire;
                    w_res     = r_acc;
                end else begin
                    w_stat = ST_RANGE;
                end
            end
            default: ;
        endcase
    end

    smvm_xram u_xram (
        .i_clk   (i_clk),
        .i_req   (w_xreq),
        .o_rdata (w_x_rdata)
    );

    smvm_accram u_accram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_areq),
        .o_rdata (w_acc_rdata),
        .o_ready (w_acc_ready)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_res;
            r_out_stat <= w_stat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_stat;

    // ---------------- assertions ----------------
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> r_state == S_MUL)
        else $error("accepted transaction did not start the pipeline");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc_ready |-> !w_s_accept)
        else $error("input accepted during accumulator clear");

    a_result_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata != '0) |-> o_m_axis_tuser == ST_OK)
        else $error("nonzero result with error status");

    a_fire_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> !w_fire)
        else $error("one item produced two results");

endmodule

`default_nettype wire
